### rtl/core/assert_macros.svh
// Assertion macros shared by the circle generator RTL.
// Expects clk_i and rst_ni in the scope of the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge, skipped while reset is asserted.
`define BCG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Check a property on every clock edge, reset included.
`define BCG_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

### rtl/core/bcg_pkg.sv
// Shared types and constants of the circle generator.
// No dependencies; imported by every other RTL file but the assertion macro header.
`default_nettype none

package bcg_pkg;

  // Coordinate and arithmetic widths
  localparam int COORD_BITS = 10;
  localparam int OFF_BITS   = COORD_BITS + 1;
  localparam int DEC_BITS   = COORD_BITS + 4;
  localparam int PIX_BITS   = 12;

  // Eight mirrored points per run
  localparam int POINTS     = 8;
  localparam int PT_BITS    = $clog2(POINTS);
  localparam logic [PT_BITS-1:0] LAST_POINT = PT_BITS'(POINTS - 1);

  // Run queue between front and back (power of two)
  localparam int QUEUE_DEPTH = 2;
  localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);

  // Decision constants
  localparam logic [DEC_BITS-1:0] DEC_THREE = DEC_BITS'(3);
  localparam logic [DEC_BITS-1:0] DEC_SIX   = DEC_BITS'(6);
  localparam logic [DEC_BITS-1:0] DEC_TEN   = DEC_BITS'(10);

  // Operation codes
  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  // One run of eight points: centre, offsets and completion flag
  typedef struct packed {
    logic [COORD_BITS-1:0] cx;
    logic [COORD_BITS-1:0] cy;
    logic [OFF_BITS-1:0]   x;
    logic [OFF_BITS-1:0]   y;
    logic                  done;
  } run_t;

endpackage

`default_nettype wire

### rtl/core/bcg_intf.sv
// Handshake channels of the circle generator: command input and point output.
// Depends on bcg_pkg for the coordinate widths.
`default_nettype none

interface bcg_in_if import bcg_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic                  op;
  logic [COORD_BITS-1:0] center_x;
  logic [COORD_BITS-1:0] center_y;
  logic [COORD_BITS-1:0] radius;

  modport source (output valid, op, center_x, center_y, radius, input ready);
  modport sink   (input valid, op, center_x, center_y, radius, output ready);
endinterface

interface bcg_out_if import bcg_pkg::*;;
  logic                       valid;
  logic                       ready;
  logic signed [PIX_BITS-1:0] pixel_x;
  logic signed [PIX_BITS-1:0] pixel_y;
  logic                       last_of_run;
  logic                       circle_done;

  modport source (output valid, pixel_x, pixel_y, last_of_run, circle_done,
                  input ready);
  modport sink   (input valid, pixel_x, pixel_y, last_of_run, circle_done,
                  output ready);
endinterface

`default_nettype wire

### rtl/core/bcg_front.sv
// Front end: accepts commands, advances the midpoint decision and offsets,
// and pushes one run per emitting command. Depends on bcg_pkg, bcg_intf.
`default_nettype none
`include "assert_macros.svh"

module bcg_front import bcg_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  bcg_in_if.sink     in_i,
  output logic       push_o,
  output run_t       push_data_o,
  input  logic       push_ready_i
);

  logic [COORD_BITS-1:0] cx_q, cx_d, cy_q, cy_d;
  logic [OFF_BITS-1:0]   x_q, x_d, y_q, y_d;
  logic [DEC_BITS-1:0]   dec_q, dec_d;
  logic                  busy_q, busy_d;
  logic                  accept;
  logic                  done;
  logic                  dec_le0;
  logic [DEC_BITS-1:0]   diff;

  assign in_i.ready = push_ready_i;
  assign accept     = in_i.valid && in_i.ready;
  assign dec_le0    = dec_q[DEC_BITS-1] || (dec_q == '0);
  assign diff       = DEC_BITS'(x_q) - DEC_BITS'(y_q);

  // Start loads a new circle; step advances a running one
  always_comb begin
    cx_d   = cx_q;
    cy_d   = cy_q;
    x_d    = x_q;
    y_d    = y_q;
    dec_d  = dec_q;
    push_o = 1'b0;
    if (accept) begin
      unique case (in_i.op)
        OP_START: begin
          cx_d   = in_i.center_x;
          cy_d   = in_i.center_y;
          x_d    = '0;
          y_d    = OFF_BITS'(in_i.radius);
          dec_d  = DEC_THREE - DEC_BITS'({in_i.radius, 1'b0});
          push_o = 1'b1;
        end
        OP_STEP: begin
          if (busy_q) begin
            if (dec_le0) begin
              dec_d = dec_q + DEC_BITS'({x_q, 2'b00}) + DEC_SIX;
            end else begin
              dec_d = dec_q + {diff[DEC_BITS-3:0], 2'b00} + DEC_TEN;
              y_d   = y_q - OFF_BITS'(1);
            end
            x_d    = x_q + OFF_BITS'(1);
            push_o = 1'b1;
          end
        end
        default: ;
      endcase
    end
    done   = (x_d >= y_d);
    busy_d = push_o ? !done : busy_q;
  end

  assign push_data_o = '{cx: cx_d, cy: cy_d, x: x_d, y: y_d, done: done};

  // Hold circle state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q   <= '0;
      cy_q   <= '0;
      x_q    <= '0;
      y_q    <= '0;
      dec_q  <= '0;
      busy_q <= 1'b0;
    end else begin
      cx_q   <= cx_d;
      cy_q   <= cy_d;
      x_q    <= x_d;
      y_q    <= y_d;
      dec_q  <= dec_d;
      busy_q <= busy_d;
    end
  end

  `BCG_ASSERT(a_idle_step_no_push, (accept && (in_i.op == OP_STEP) && !busy_q) |-> !push_o, "step while idle pushed a run")
  `BCG_ASSERT(a_idle_step_keeps, (accept && (in_i.op == OP_STEP) && !busy_q) |=> $stable(x_q) && $stable(dec_q), "step while idle changed state")

endmodule

`default_nettype wire

### rtl/core/bcg_queue.sv
// Short run queue that decouples the command front end from point output.
// Depends on bcg_pkg.
`default_nettype none
`include "assert_macros.svh"

module bcg_queue import bcg_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  run_t push_data_i,
  output logic push_ready_o,
  output logic head_valid_o,
  output run_t head_o,
  input  logic pop_i
);

  run_t                mem_q [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
  logic [PTR_BITS:0]   cnt_q;

  assign push_ready_o = (cnt_q != (PTR_BITS+1)'(QUEUE_DEPTH));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_ptr_q];

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + PTR_BITS'(1);
      if (pop_i)  rd_ptr_q <= rd_ptr_q + PTR_BITS'(1);
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + (PTR_BITS+1)'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - (PTR_BITS+1)'(1);
      end
    end
  end

  // Store pushed runs
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_data_i;
  end

  `BCG_ASSERT(a_no_push_full, push_i |-> push_ready_o, "run pushed into full queue")
  `BCG_ASSERT(a_no_pop_empty, pop_i |-> head_valid_o, "run popped from empty queue")
  `BCG_ASSERT_ALWAYS(a_cnt_range, cnt_q <= (PTR_BITS+1)'(QUEUE_DEPTH), "queue count out of range")

endmodule

`default_nettype wire

### rtl/core/bcg_back.sv
// Back end: walks the eight mirrored points of the head run, one per cycle
// unless stalled, into a registered output. Depends on bcg_pkg and bcg_intf.
`default_nettype none
`include "assert_macros.svh"

module bcg_back import bcg_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    head_valid_i,
  input  run_t    head_i,
  output logic    pop_o,
  bcg_out_if.source out_o
);

  logic [PT_BITS-1:0]  pt_q;
  logic                ov_q;
  logic [PIX_BITS-1:0] px_q, py_q, px_d, py_d;
  logic                last_q, done_q;
  logic                load;
  logic [OFF_BITS-1:0] a, b;
  logic                neg_a, neg_b;

  assign load  = head_valid_i && (!ov_q || out_o.ready);
  assign pop_o = load && (pt_q == LAST_POINT);

  // Select offsets and signs for the current octant
  always_comb begin
    a     = pt_q[PT_BITS-1] ? head_i.y : head_i.x;
    b     = pt_q[PT_BITS-1] ? head_i.x : head_i.y;
    neg_a = pt_q[PT_BITS-1] ? pt_q[1] : pt_q[0];
    neg_b = pt_q[PT_BITS-1] ? pt_q[0] : pt_q[1];
    px_d  = neg_a ? PIX_BITS'(head_i.cx) - PIX_BITS'(a)
                  : PIX_BITS'(head_i.cx) + PIX_BITS'(a);
    py_d  = neg_b ? PIX_BITS'(head_i.cy) - PIX_BITS'(b)
                  : PIX_BITS'(head_i.cy) + PIX_BITS'(b);
  end

  // Advance point index and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pt_q <= '0;
      ov_q <= 1'b0;
    end else begin
      if (load) begin
        pt_q <= pt_q + PT_BITS'(1);
        ov_q <= 1'b1;
      end else if (out_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  // Capture point payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      px_q   <= px_d;
      py_q   <= py_d;
      last_q <= (pt_q == LAST_POINT);
      done_q <= head_i.done;
    end
  end

  assign out_o.valid       = ov_q;
  assign out_o.pixel_x     = px_q;
  assign out_o.pixel_y     = py_q;
  assign out_o.last_of_run = last_q;
  assign out_o.circle_done = done_q;

  `BCG_ASSERT(a_head_held, (pt_q != '0) |-> head_valid_i, "run left queue before its eighth point")

endmodule

`default_nettype wire

### rtl/core/bresenham_circle_generator_unit.sv
// Midpoint circle generator: a start command loads centre and radius, each
// step command advances one column, and every emitting command produces the
// eight mirrored points of the current offset, one transfer per cycle while
// the output is ready, the last flagged with last_of_run and all flagged with
// circle_done once x >= y. Commands are accepted one per cycle while the
// two-entry run queue has room; the single-point output port limits the
// sustained rate of emitting commands, and a step with no circle running is
// accepted and produces nothing. Results pass through the run queue and then
// the registered output stage before they reach the output channel.
// Depends on bcg_pkg, bcg_intf, bcg_front, bcg_queue and bcg_back.
`default_nettype none

module bresenham_circle_generator_unit import bcg_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  bcg_in_if.sink     in_i,
  bcg_out_if.source  out_o
);

  logic push, push_ready, head_valid, pop;
  run_t push_data, head;

  // Accept and classify commands
  bcg_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .push_o       (push),
    .push_data_o  (push_data),
    .push_ready_i (push_ready)
  );

  // Buffer runs between the two sides
  bcg_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (push_data),
    .push_ready_o (push_ready),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop)
  );

  // Emit mirrored points
  bcg_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_o        (out_o)
  );

endmodule

`default_nettype wire
